// ----- hw/rtl/mhpq_pkg.sv -----
package mhpq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    typedef enum logic {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // operation as classified by the front end
    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_EXTRACT   = 2'd1,
        OP_REJ_FULL  = 2'd2,
        OP_REJ_EMPTY = 2'd3
    } t_op_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_EXT_LAST,
        S_EXT_CMP,
        S_DONE
    } t_bstate;

    typedef struct packed {
        t_cmd                       command;
        logic signed [VALUE_W-1:0]  value;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  extracted;
        t_status                    status;
        logic signed [VALUE_W-1:0]  current_min;
        logic                       is_empty;
        logic [COUNT_W-1:0]         entry_count;
    } t_out;

    typedef struct packed {
        t_op_kind                   kind;
        logic signed [VALUE_W-1:0]  value;
    } t_op;

endpackage

// ----- hw/rtl/mhpq_ram.sv -----
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr_b,
    output logic [WIDTH-1:0]          o_rdata_a,
    output logic [WIDTH-1:0]          o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- hw/rtl/mhpq_front.sv -----
module mhpq_front
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_in   i_item,
    output logic  o_busy,
    output logic  o_op_valid,
    output t_op   o_op,
    input  logic  i_pop
);

    localparam int CW = $clog2(CAPACITY + 1);

    // two-entry op queue
    t_op         r_q [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_used;
    logic [CW-1:0] r_cnt;     // count as it will be once queued ops retire

    logic        accept;
    t_op         op_new;
    logic [CW-1:0] n_cnt;

    assign o_busy     = (r_used == 2'd2);
    assign accept     = i_start && !o_busy;
    assign o_op_valid = (r_used != 2'd0);
    assign o_op       = r_q[r_rd];

    always_comb begin
        op_new.value = i_item.value;
        n_cnt        = r_cnt;
        unique case (i_item.command)
            CMD_INSERT: begin
                if (r_cnt >= CW'(CAPACITY)) begin
                    op_new.kind = OP_REJ_FULL;
                end else begin
                    op_new.kind = OP_INSERT;
                    n_cnt       = r_cnt + CW'(1);
                end
            end
            CMD_EXTRACT: begin
                if (r_cnt == '0) begin
                    op_new.kind = OP_REJ_EMPTY;
                end else begin
                    op_new.kind = OP_EXTRACT;
                    n_cnt       = r_cnt - CW'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_used <= 2'd0;
            r_cnt  <= '0;
        end else begin
            if (accept) begin
                r_wr  <= ~r_wr;
                r_cnt <= n_cnt;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_used <= r_used + 2'(accept) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr] <= op_new;
        end
    end

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_used != 2'd0)
        else $error("op queue popped while empty");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= 2'd2)
        else $error("op queue overfilled");
`endif

endmodule

// ----- hw/rtl/mhpq_back.sv -----
module mhpq_back
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_op_valid,
    input  t_op                          i_op,
    output logic                         o_pop,
    output logic                         o_we,
    output logic [$clog2(CAPACITY)-1:0]  o_waddr,
    output logic [VALUE_W-1:0]           o_wdata,
    output logic [$clog2(CAPACITY)-1:0]  o_raddr_a,
    output logic [$clog2(CAPACITY)-1:0]  o_raddr_b,
    input  logic [VALUE_W-1:0]           i_rdata_a,
    input  logic [VALUE_W-1:0]           i_rdata_b,
    output logic                         o_valid,
    output t_out                         o_result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int LW = AW + 2;

    t_bstate                    r_state, n_state;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic signed [VALUE_W-1:0]  r_root, n_root;
    logic signed [VALUE_W-1:0]  r_val, n_val;
    logic [AW-1:0]              r_pos, n_pos;
    logic signed [VALUE_W-1:0]  r_removed, n_removed;
    t_status                    r_status, n_status;
    t_out                       r_out, n_out;
    logic                       r_out_valid, n_out_valid;

    // sift-up compare
    logic signed [VALUE_W-1:0]  par_val;
    logic [AW-1:0]              par_pos;
    logic                       ins_up;

    // sift-down compare
    logic [LW-1:0]              left_full, right_full;
    logic                       left_ok, right_ok, take_l, take_r, ext_moved;
    logic signed [VALUE_W-1:0]  l_val, r_val_ch, bv_l, best_val;
    logic [AW-1:0]              best_pos;
    logic [LW-1:0]              cl_next;

    assign par_val = $signed(i_rdata_a);
    assign par_pos = AW'((r_pos - AW'(1)) >> 1);
    assign ins_up  = (r_val < par_val);

    assign left_full  = {1'b0, r_pos, 1'b1};
    assign right_full = left_full + LW'(1);
    assign left_ok    = (left_full < LW'(r_cnt));
    assign right_ok   = (right_full < LW'(r_cnt));
    assign l_val      = $signed(i_rdata_a);
    assign r_val_ch   = $signed(i_rdata_b);
    assign take_l     = left_ok && (l_val < r_val);
    assign bv_l       = take_l ? l_val : r_val;
    assign take_r     = right_ok && (r_val_ch < bv_l);
    assign best_val   = take_r ? r_val_ch : bv_l;
    assign ext_moved  = take_l || take_r;
    assign best_pos   = take_r ? right_full[AW-1:0] : left_full[AW-1:0];
    assign cl_next    = {1'b0, best_pos, 1'b1};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    unique case (i_op.kind)
                        OP_INSERT:    n_state = (r_cnt == '0) ? S_INS_PUT : S_INS_CMP;
                        OP_EXTRACT:   n_state = S_EXT_LAST;
                        OP_REJ_FULL:  n_state = S_DONE;
                        OP_REJ_EMPTY: n_state = S_DONE;
                    endcase
                end
            end
            S_INS_CMP: begin
                if (ins_up) begin
                    n_state = (par_pos == '0) ? S_INS_PUT : S_INS_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS_PUT:  n_state = S_DONE;
            S_EXT_LAST: n_state = (r_cnt == '0) ? S_DONE : S_EXT_CMP;
            S_EXT_CMP:  n_state = ext_moved ? S_EXT_CMP : S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_pop       = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_pos;
        o_wdata     = r_val;
        o_raddr_a   = '0;
        o_raddr_b   = '0;
        n_cnt       = r_cnt;
        n_val       = r_val;
        n_pos       = r_pos;
        n_removed   = r_removed;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    o_pop     = 1'b1;
                    n_removed = '0;
                    n_status  = ST_OK;
                    unique case (i_op.kind)
                        OP_INSERT: begin
                            n_val     = i_op.value;
                            n_pos     = AW'(r_cnt);
                            n_cnt     = r_cnt + CW'(1);
                            o_raddr_a = AW'((AW'(r_cnt) - AW'(1)) >> 1);
                        end
                        OP_EXTRACT: begin
                            n_removed = r_root;
                            n_cnt     = r_cnt - CW'(1);
                            o_raddr_a = AW'(r_cnt - CW'(1));
                        end
                        OP_REJ_FULL:  n_status = ST_FULL;
                        OP_REJ_EMPTY: n_status = ST_EMPTY;
                    endcase
                end
            end
            S_INS_CMP: begin
                o_we = 1'b1;
                if (ins_up) begin
                    o_wdata   = i_rdata_a;
                    n_pos     = par_pos;
                    o_raddr_a = AW'((par_pos - AW'(1)) >> 1);
                end
            end
            S_INS_PUT: begin
                o_we = 1'b1;
            end
            S_EXT_LAST: begin
                // last entry moves to the root; fetch both children of the root
                n_val     = $signed(i_rdata_a);
                n_pos     = '0;
                o_raddr_a = AW'(1);
                o_raddr_b = AW'(2);
            end
            S_EXT_CMP: begin
                o_we = 1'b1;
                if (ext_moved) begin
                    o_wdata   = best_val;
                    n_pos     = best_pos;
                    o_raddr_a = cl_next[AW-1:0];
                    o_raddr_b = AW'(cl_next + LW'(1));
                end
            end
            S_DONE: begin
                n_out_valid         = 1'b1;
                n_out.extracted     = r_removed;
                n_out.status        = r_status;
                n_out.current_min   = (r_cnt != '0) ? r_root : '0;
                n_out.is_empty      = (r_cnt == '0);
                n_out.entry_count   = COUNT_W'(r_cnt);
            end
            default: ;
        endcase
        n_root = (o_we && o_waddr == '0) ? $signed(o_wdata) : r_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root    <= n_root;
        r_val     <= n_val;
        r_pos     <= n_pos;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef ASSERT_OFF
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe held for two cycles");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_siftdown_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXT_CMP |-> r_cnt != '0)
        else $error("sift-down on an empty heap");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE && i_op_valid)
        else $error("op taken outside idle");
`endif

endmodule

// ----- hw/rtl/min_heap_priority_queue.sv -----
// Binary min-heap priority queue of signed 32-bit values.
// Command channel: drive i_item and raise start; the beat is taken on a rising edge
// where start is high and busy is low. command 0 inserts value, 1 extracts the minimum.
// Result channel: o_valid is high for exactly one cycle per command, in command order,
// with o_result holding the extracted value (0 for inserts), status (0 ok, 1 extract
// from empty, 2 insert into full), the root after the step, an empty flag and the count.
// The receiver cannot stall; each result beat must be taken in its strobe cycle.
// A two-entry op queue parts the front end (classifies ok/empty/full) from the sift
// engine, so up to two commands can wait while the engine works; busy is high while
// both queue slots are taken.
// Steps: the engine takes a queued command in idle; an insert compares against parents
// until its slot is written, an extract moves the last entry to the root and sifts it
// down, a rejected command goes straight to the result state, and the result is
// registered; swaps <= floor(log2(count after)). The engine works on one command at a
// time, so a queued command waits for the ones ahead of it. The sift loop moves one
// tree level per cycle through the two-read-port RAM (both children fetched at once).
// Synchronous reset empties the heap and the queue; the store itself is not cleared,
// only entries below the count are ever used.
module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_in   i_item,
    output logic  busy,
    output logic  o_valid,
    output t_out  o_result
);

    localparam int AW = $clog2(CAPACITY);

    logic                 op_valid;
    t_op                  op;
    logic                 op_pop;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [VALUE_W-1:0]   ram_wdata;
    logic [AW-1:0]        ram_raddr_a, ram_raddr_b;
    logic [VALUE_W-1:0]   ram_rdata_a, ram_rdata_b;

    mhpq_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .o_busy     (busy),
        .o_op_valid (op_valid),
        .o_op       (op),
        .i_pop      (op_pop)
    );

    mhpq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_pop      (op_pop),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_raddr_a  (ram_raddr_a),
        .o_raddr_b  (ram_raddr_b),
        .i_rdata_a  (ram_rdata_a),
        .i_rdata_b  (ram_rdata_b),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    // heap store
    mhpq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

endmodule

// ----- sim/min_heap_priority_queue_tb.sv -----
module min_heap_priority_queue_tb
    import mhpq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Heap depth under test.
    localparam int HEAP_DEPTH     = 64;
    localparam int DIRECTED_BEATS = 23;
    localparam int RANDOM_BEATS   = 1750;
    localparam int TOTAL_BEATS    = DIRECTED_BEATS + RANDOM_BEATS;
    // Sender stops idling for the final stretch so back-to-back beats get covered.
    localparam int QUIET_FROM     = TOTAL_BEATS - 200;
    localparam int TAIL_CYCLES    = 30;
    // Worst legal gap between beats is one idle burst plus the engine's work; this is
    // far above that.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_CAP      = 40;

    typedef enum int {
        PH_MIXED,
        PH_FILL,
        PH_DRAIN,
        PH_FALL
    } t_phase;

    typedef enum int {
        VS_WIDE,
        VS_NARROW,
        VS_EDGE,
        VS_FALLING
    } t_vstyle;

    //------------------------------------------------------------------------
    // Scoreboard: shadow heap plus FIFO of expected result beats.
    //------------------------------------------------------------------------
    class heap_scoreboard;
        logic signed [VALUE_W-1:0] heap_mem [HEAP_DEPTH];
        int   fill;
        t_out expected_replies [$];
        int   errors;
        int   n_insert, n_extract, n_underflow, n_full, n_checked, peak_fill;

        function new();
            fill = 0;
            errors = 0;
            n_insert = 0;
            n_extract = 0;
            n_underflow = 0;
            n_full = 0;
            n_checked = 0;
            peak_fill = 0;
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP) begin
                $display("[%0t] ERROR: %s", $time, msg);
            end
            errors++;
        endtask

        function void swap_slots(int a, int b);
            logic signed [VALUE_W-1:0] tmp;
            tmp         = heap_mem[a];
            heap_mem[a] = heap_mem[b];
            heap_mem[b] = tmp;
        endfunction

        // Applies one command to the shadow heap and returns the reply beat.
        function t_out apply_heap_op(t_in cmd);
            t_out r;
            int   pos;
            int   kid;
            int   pick;
            bit   moving;
            r        = '0;
            r.status = ST_OK;
            if (cmd.command == CMD_INSERT) begin
                if (fill >= HEAP_DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    pos           = fill;
                    heap_mem[pos] = cmd.value;
                    fill++;
                    n_insert++;
                    // sift up while strictly below the parent
                    while (pos > 0 && heap_mem[pos] < heap_mem[(pos - 1) / 2]) begin
                        swap_slots(pos, (pos - 1) / 2);
                        pos = (pos - 1) / 2;
                    end
                end
            end else if (fill == 0) begin
                r.status = ST_EMPTY;
                n_underflow++;
            end else begin
                r.extracted = heap_mem[0];
                heap_mem[0] = heap_mem[fill - 1];
                fill--;
                n_extract++;
                // sift down; left child wins a tie, swap only when strictly smaller
                pos    = 0;
                moving = 1'b1;
                while (moving) begin
                    pick = pos;
                    kid  = 2 * pos + 1;
                    if (kid < fill && heap_mem[kid] < heap_mem[pick]) begin
                        pick = kid;
                    end
                    if (kid + 1 < fill && heap_mem[kid + 1] < heap_mem[pick]) begin
                        pick = kid + 1;
                    end
                    if (pick == pos) begin
                        moving = 1'b0;
                    end else begin
                        swap_slots(pos, pick);
                        pos = pick;
                    end
                end
            end
            if (fill > peak_fill) begin
                peak_fill = fill;
            end
            r.current_min = (fill > 0) ? heap_mem[0] : '0;
            r.is_empty    = (fill == 0);
            r.entry_count = fill[COUNT_W-1:0];
            return r;
        endfunction

        function void note_command(t_in cmd);
            expected_replies = {expected_replies, apply_heap_op(cmd)};
        endfunction

        task check_reply(t_out got);
            t_out want;
            if (expected_replies.size() == 0) begin
                report("result beat with nothing outstanding");
                return;
            end
            want = expected_replies.pop_front();
            n_checked++;
            if (got.extracted !== want.extracted) begin
                report($sformatf("extracted got %0d want %0d", got.extracted, want.extracted));
            end
            if (got.status !== want.status) begin
                report($sformatf("status got %0d want %0d", got.status, want.status));
            end
            if (got.current_min !== want.current_min) begin
                report($sformatf("current_min got %0d want %0d",
                                 got.current_min, want.current_min));
            end
            if (got.is_empty !== want.is_empty) begin
                report($sformatf("is_empty got %0b want %0b", got.is_empty, want.is_empty));
            end
            if (got.entry_count !== want.entry_count) begin
                report($sformatf("entry_count got %0d want %0d",
                                 got.entry_count, want.entry_count));
            end
        endtask

        function int outstanding();
            return expected_replies.size();
        endfunction

        task close_out();
            if (expected_replies.size() != 0) begin
                report($sformatf("%0d result beats never arrived", expected_replies.size()));
            end
        endtask
    endclass

    //------------------------------------------------------------------------
    // Clock, reset, DUT
    //------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_item  = '0;
    logic busy;
    logic o_valid;
    t_out o_result;

    always #5ns i_clk = ~i_clk;

    min_heap_priority_queue #(
        .CAPACITY (HEAP_DEPTH)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    heap_scoreboard sb;

    // Stimulus-side bookkeeping: the stimulus steers on its own count so it
    // never races the monitor within an edge.
    int sent        = 0;
    int shadow_fill = 0;
    int falling_val = 32'sh7fff_0000;
    int idle_cycles = 0;

    //------------------------------------------------------------------------
    // Monitor: everything sampled at the edge sees pre-edge values, since both
    // sides only change on NBAs.
    //------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                sb.check_reply(o_result);
            end
            if (start && !busy) begin
                sb.note_command(i_item);
            end
        end
    end

    // Watchdog: any stretch with no beat moving either way is a hang.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    //------------------------------------------------------------------------
    // Driver tasks
    //------------------------------------------------------------------------

    // One command beat, optionally preceded by an idle burst. Called at a
    // rising edge; returns at the edge that accepted the beat, with start
    // still high so the next beat can follow with no bubble.
    task automatic issue(input t_cmd c, input logic signed [VALUE_W-1:0] v,
                         input int gap_pct);
        t_in it;
        it.command = c;
        it.value   = v;
        if (sent >= QUIET_FROM) begin
            gap_pct = 0;
        end
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (c == CMD_INSERT) begin
            if (shadow_fill < HEAP_DEPTH) begin
                shadow_fill++;
            end
        end else if (shadow_fill > 0) begin
            shadow_fill--;
        end
        sent++;
    endtask

    // Sender holds off until every result in flight has come back.
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value(t_vstyle vs);
        logic signed [VALUE_W-1:0] v;
        case (vs)
            VS_WIDE: begin
                v = $urandom;
            end
            VS_NARROW: begin
                // tight range gives plenty of ties in the sift compares
                v = $signed($urandom_range(0, 8)) - 4;
            end
            VS_EDGE: begin
                case ($urandom_range(5))
                    0: v = 32'sh7fff_ffff;
                    1: v = 32'sh8000_0000;
                    2: v = 0;
                    3: v = -1;
                    4: v = 32'sh7fff_fffe;
                    default: v = 32'sh8000_0001;
                endcase
            end
            default: begin
                // strictly falling inserts sift all the way to the root unless a smaller value is stored
                falling_val = falling_val - $urandom_range(1, 5000);
                v = falling_val;
            end
        endcase
        return v;
    endfunction

    function automatic t_cmd pick_cmd(int insert_pct);
        return ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
    endfunction

    //------------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------------
    initial begin
        int      phase_idx;
        int      len;
        int      gap_pct;
        int      ins_pct;
        int      n;
        t_phase  ph;
        t_vstyle vs;

        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: underflow on an empty heap, both extremes, zero and +/-1,
        // ties, full drain back to empty, alternating bit patterns.
        issue(CMD_EXTRACT, 32'sh1234_5678, 0);
        issue(CMD_INSERT, 0, 0);
        issue(CMD_INSERT, 32'sh7fff_ffff, 0);
        issue(CMD_INSERT, 32'sh8000_0000, 0);
        issue(CMD_INSERT, -1, 0);
        issue(CMD_INSERT, 1, 0);
        issue(CMD_INSERT, 5, 0);
        issue(CMD_INSERT, 5, 0);
        issue(CMD_INSERT, 5, 0);
        repeat (8) issue(CMD_EXTRACT, 32'shffff_ffff, 0);
        issue(CMD_EXTRACT, 0, 0);
        issue(CMD_INSERT, 32'sh5555_5555, 0);
        issue(CMD_INSERT, 32'shaaaa_aaaa, 0);
        issue(CMD_EXTRACT, 32'sh5555_5555, 0);
        issue(CMD_EXTRACT, 32'shaaaa_aaaa, 0);
        issue(CMD_EXTRACT, 0, 0);
        settle();

        // Random phases. The first two force a fill to capacity (with inserts
        // bounced off the full heap) and a drain past empty; after that the
        // mix is random, mostly balanced traffic with well-formed content.
        phase_idx = 0;
        while (sent < TOTAL_BEATS) begin
            case ($urandom_range(2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 35;
            endcase
            vs = t_vstyle'($urandom_range(3));
            if (phase_idx == 0) begin
                ph = PH_FILL;
            end else if (phase_idx == 1) begin
                ph = PH_DRAIN;
            end else begin
                case ($urandom_range(6))
                    0: ph = PH_FILL;
                    1: ph = PH_DRAIN;
                    2: ph = PH_FALL;
                    default: ph = PH_MIXED;
                endcase
            end

            case (ph)
                PH_FILL: begin
                    n = 0;
                    while (shadow_fill < HEAP_DEPTH && n < 300) begin
                        issue(pick_cmd(90), pick_value(vs), gap_pct);
                        n++;
                    end
                    // a few beats against the full store
                    repeat ($urandom_range(1, 4)) issue(CMD_INSERT, pick_value(vs), gap_pct);
                end
                PH_DRAIN: begin
                    n = 0;
                    while (shadow_fill > 0 && n < 300) begin
                        issue(pick_cmd(10), pick_value(vs), gap_pct);
                        n++;
                    end
                    repeat ($urandom_range(1, 3)) issue(CMD_EXTRACT, pick_value(vs), gap_pct);
                end
                PH_FALL: begin
                    len = $urandom_range(10, 40);
                    repeat (len) issue(CMD_INSERT, pick_value(VS_FALLING), gap_pct);
                    repeat (len) issue(pick_cmd(15), pick_value(vs), gap_pct);
                end
                default: begin
                    len     = $urandom_range(20, 80);
                    ins_pct = $urandom_range(35, 65);
                    repeat (len) issue(pick_cmd(ins_pct), pick_value(vs), gap_pct);
                end
            endcase

            // every third phase the sender waits for the queue to run dry,
            // except in the final gap-free stretch
            if (phase_idx % 3 == 2 && sent < QUIET_FROM) begin
                settle();
            end
            phase_idx++;
        end

        // Drain everything in flight, then allow the block's latency once more
        // for any stray beat.
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.close_out();

        $display("Covered %0d command beats over %0d phases, %0d results checked.",
                 sent, phase_idx, sb.n_checked);
        $display("Inserts %0d, extracts %0d, empty underflows %0d, full rejects %0d, peak %0d.",
                 sb.n_insert, sb.n_extract, sb.n_underflow, sb.n_full, sb.peak_fill);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
